FILE: src/page_buffer_lru_pin_manager_assert.svh
// Assertion macros for the page buffer LRU pin manager.
// Used by the top level; depends on clk and rst_n in the including scope.
`ifndef PAGE_BUFFER_LRU_PIN_MANAGER_ASSERT_SVH
`define PAGE_BUFFER_LRU_PIN_MANAGER_ASSERT_SVH

`define PBLRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PBLRU_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);

`endif

FILE: src/pblru_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the page buffer LRU pin manager.
// No dependencies.
package pblru_pkg;

  localparam int POS_BITS = 6;

  typedef enum logic [2:0] {
    OP_LOAD, OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE_PAGE, OP_FORCE_FILE,
    OP_REL_FILE, OP_REL_ALL
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT, ST_MISS, ST_WRITEBACK, ST_DONE, ST_NOTFOUND, ST_NOFRAME
  } status_t;

  typedef struct packed {
    logic        valid;
    logic        pinned;
    logic        dirty;
    logic [3:0]  file;
    logic [15:0] page;
  } ent_t;

  typedef struct packed {
    logic                en;
    logic [POS_BITS-1:0] lo;
    logic [POS_BITS-1:0] hi;
    ent_t                ent;
  } cmd_t;

endpackage

FILE: src/pblru_cell.sv
`timescale 1ns / 1ps
// One frame cell of the recency chain: holds an entry, shifts from its upper neighbor.
// Depends on pblru_pkg.
module pblru_cell import pblru_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [3:0]  key_file_i,
  input  logic [15:0] key_page_i,
  input  ent_t        up_i,
  output ent_t        ent_o,
  output logic        hit_o
);

  localparam logic [POS_BITS-1:0] MY = POS_BITS'(IDX);

  ent_t ent_r;
  ent_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.en) begin
      if (MY == cmd.hi) begin
        ent_nxt = cmd.ent;
      end else if (MY >= cmd.lo && MY < cmd.hi) begin
        ent_nxt = up_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;
  assign hit_o = ent_r.valid && ent_r.file == key_file_i && ent_r.page == key_page_i;

endmodule

FILE: src/page_buffer_lru_pin_manager.sv
`timescale 1ns / 1ps
// Page buffer frame manager with LRU replacement and pinning; top level.
// Depends on pblru_pkg, pblru_cell and page_buffer_lru_pin_manager_assert.svh.
// Frames sit in a chain of cells ordered by recency, the least recently used at
// cell 0. A page request executes after acceptance and, when it also reports a
// write-back, issues a second beat. A file-wide request visits every resident
// frame once, one per cycle, then issues a final beat. Each step stalls while the
// result register waits on out_ready. A new request is taken once the previous
// one has issued its final beat.
module page_buffer_lru_pin_manager import pblru_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int FILES     = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_file_id,
  input  logic [15:0] in_page_num,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_file,
  output logic [15:0] out_page,
  output logic        out_last
);

  `include "page_buffer_lru_pin_manager_assert.svh"

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN, S_WALK} state_t;

  localparam logic [POS_BITS-1:0] FULL = POS_BITS'(FRAMES);
  localparam logic [POS_BITS-1:0] TOPF = POS_BITS'(FRAMES - 1);

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [3:0]          file_r;
  logic [15:0]         page_r;
  logic [POS_BITS-1:0] count_r, count_nxt;
  logic [POS_BITS-1:0] ptr_r, ptr_nxt;
  logic [POS_BITS-1:0] left_r, left_nxt;
  status_t             fin_r, fin_nxt;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [3:0]          out_file_r;
  logic [15:0]         out_page_r;
  logic                out_last_r;

  cmd_t                cmd;
  ent_t                ents [FRAMES];
  logic [FRAMES-1:0]   hits;
  logic [FRAMES-1:0]   valids;

  logic                can_emit, em;
  status_t             em_status;
  logic [3:0]          em_file;
  logic [15:0]         em_page;
  logic                em_last;

  logic                hit_any, vic_any, ok, match;
  logic [POS_BITS-1:0] hpos, vpos, top_pos;
  ent_t                hent, vent, cent, newent;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    ent_t up;
    if (k == FRAMES - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = ents[k+1];
    end
    pblru_cell #(.IDX(k)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .key_file_i (file_r),
      .key_page_i (page_r),
      .up_i       (up),
      .ent_o      (ents[k]),
      .hit_o      (hits[k])
    );
    assign valids[k] = ents[k].valid;
  end

  always_comb begin
    hit_any = 1'b0;
    vic_any = 1'b0;
    hpos    = '0;
    vpos    = '0;
    hent    = '0;
    vent    = '0;
    cent    = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (hits[k]) begin
        hit_any = 1'b1;
        hpos    = POS_BITS'(k);
        hent    = ents[k];
      end
      if (ents[k].valid && !ents[k].pinned) begin
        vic_any = 1'b1;
        vpos    = POS_BITS'(k);
        vent    = ents[k];
      end
      if (POS_BITS'(k) == ptr_r) begin
        cent = ents[k];
      end
    end
  end

  assign ok = (32'(file_r) < FILES) &&
              ((PAGE_BITS >= 16) || ((32'(page_r) >> PAGE_BITS) == 32'd0));
  assign top_pos  = count_r - 1'b1;
  assign can_emit = !out_valid_r || out_ready;
  assign match    = (op_r == OP_REL_ALL) || ((32'(file_r) < FILES) && cent.file == file_r);

  always_comb begin
    newent        = '0;
    newent.valid  = 1'b1;
    newent.pinned = 1'b1;
    newent.file   = file_r;
    newent.page   = page_r;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    left_nxt     = left_r;
    fin_nxt      = fin_r;
    cmd          = '0;
    em           = 1'b0;
    em_status    = ST_DONE;
    em_file      = file_r;
    em_page      = page_r;
    em_last      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
          if (op_r == OP_FORCE_FILE || op_r == OP_REL_FILE || op_r == OP_REL_ALL) begin
            ptr_nxt   = '0;
            left_nxt  = count_r;
            state_nxt = S_WALK;
          end else if (!ok || !hit_any) begin
            em = 1'b1;
            if (op_r == OP_LOAD && ok) begin
              if (count_r == FULL) begin
                if (!vic_any) begin
                  em_status = ST_NOFRAME;
                end else begin
                  cmd.en  = 1'b1;
                  cmd.lo  = vpos;
                  cmd.hi  = TOPF;
                  cmd.ent = newent;
                  if (vent.dirty) begin
                    em_status = ST_WRITEBACK;
                    em_file   = vent.file;
                    em_page   = vent.page;
                    em_last   = 1'b0;
                    fin_nxt   = ST_MISS;
                    state_nxt = S_FIN;
                  end else begin
                    em_status = ST_MISS;
                  end
                end
              end else begin
                cmd.en    = 1'b1;
                cmd.lo    = count_r;
                cmd.hi    = count_r;
                cmd.ent   = newent;
                count_nxt = count_r + 1'b1;
                em_status = ST_MISS;
              end
            end else begin
              em_status = ST_NOTFOUND;
            end
          end else begin
            em      = 1'b1;
            cmd.en  = 1'b1;
            cmd.lo  = hpos;
            cmd.hi  = hpos;
            cmd.ent = hent;
            priority case (op_r)
              OP_LOAD: begin
                cmd.hi    = top_pos;
                em_status = ST_HIT;
              end
              OP_PIN:   cmd.ent.pinned = 1'b1;
              OP_UNPIN: cmd.ent.pinned = 1'b0;
              OP_DIRTY: cmd.ent.dirty  = 1'b1;
              default: begin
                cmd.hi        = top_pos;
                cmd.ent.dirty = 1'b0;
                if (hent.dirty) begin
                  em_status = ST_WRITEBACK;
                  em_last   = 1'b0;
                  fin_nxt   = ST_DONE;
                  state_nxt = S_FIN;
                end
              end
            endcase
          end
        end
      end
      S_FIN: begin
        if (can_emit) begin
          em        = 1'b1;
          em_status = fin_r;
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (can_emit) begin
          if (left_r == '0) begin
            em        = 1'b1;
            em_file   = (op_r == OP_REL_ALL) ? 4'd0 : file_r;
            em_page   = '0;
            state_nxt = S_IDLE;
          end else begin
            left_nxt = left_r - 1'b1;
            if (match) begin
              if (cent.dirty) begin
                em        = 1'b1;
                em_status = ST_WRITEBACK;
                em_file   = cent.file;
                em_page   = cent.page;
                em_last   = 1'b0;
              end
              cmd.en = 1'b1;
              cmd.lo = ptr_r;
              cmd.hi = top_pos;
              if (op_r == OP_FORCE_FILE) begin
                cmd.ent       = cent;
                cmd.ent.dirty = 1'b0;
              end else begin
                cmd.ent   = '0;
                count_nxt = count_r - 1'b1;
              end
            end else begin
              ptr_nxt = ptr_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      left_r      <= '0;
      fin_r       <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      left_r  <= left_nxt;
      fin_r   <= fin_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (em) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= op_t'(in_opcode);
      file_r <= in_file_id;
      page_r <= in_page_num;
    end
    if (em) begin
      out_status_r <= em_status;
      out_file_r   <= em_file;
      out_page_r   <= em_page;
      out_last_r   <= em_last;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_file   = out_file_r;
  assign out_page   = out_page_r;
  assign out_last   = out_last_r;

  `PBLRU_ASSERT(a_count_range, count_r <= FULL, "resident count exceeds frames")
  `PBLRU_ASSERT(a_count_valid, $countones(valids) == 32'(count_r), "count and valid cells disagree")
  `PBLRU_ASSERT(a_hit_unique, $onehot0(hits), "page resident in more than one frame")
  `PBLRU_ASSERT_IMPL(a_wb_not_last, out_valid_r && out_status_r == ST_WRITEBACK, !out_last_r,
    "write-back beat marked last")

endmodule

FILE: dv/page_buffer_lru_pin_manager_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the page buffer LRU pin manager.
// Drives random and directed requests, predicts frame state and LRU order, checks every beat.
// Depends on pblru_pkg and page_buffer_lru_pin_manager.
module page_buffer_lru_pin_manager_test;
  import pblru_pkg::*;

  localparam int NFR = 16;
  localparam int NFILES = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    op_t         op;
    logic [3:0]  file;
    logic [15:0] page;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  file;
    logic [15:0] page;
    logic        last;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic [3:0] in_file_id = '0;
  logic [15:0] in_page_num = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [3:0] out_file;
  logic [15:0] out_page;
  logic out_last;

  page_buffer_lru_pin_manager u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_file_id(in_file_id), .in_page_num(in_page_num),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_file(out_file), .out_page(out_page),
    .out_last(out_last)
  );

  always #1 clk = ~clk;

  // pool model
  logic        fr_valid [NFR];
  logic        fr_pinned [NFR];
  logic        fr_dirty [NFR];
  logic [3:0]  fr_file [NFR];
  logic [15:0] fr_page [NFR];
  int          fr_rank [NFR];
  int          resident;

  req_t  pending_reqs [$];
  resp_t expected_beats [$];
  int    errors = 0;
  bit    stim_done = 0;
  bit    hold_off = 0;

  function automatic void push_beat(status_t s, logic [3:0] f, logic [15:0] p, logic l);
    resp_t r;
    r.status = s; r.file = f; r.page = p; r.last = l;
    expected_beats = {expected_beats, r};
  endfunction

  function automatic void queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void make_mru(int i);
    for (int g = 0; g < NFR; g++)
      if (fr_valid[g] && fr_rank[g] > fr_rank[i]) fr_rank[g]--;
    fr_rank[i] = resident - 1;
  endfunction

  function automatic void free_frame(int i);
    for (int g = 0; g < NFR; g++)
      if (fr_valid[g] && fr_rank[g] > fr_rank[i]) fr_rank[g]--;
    fr_valid[i] = 0; fr_pinned[i] = 0; fr_dirty[i] = 0;
    fr_file[i] = 0; fr_page[i] = 0; fr_rank[i] = 0;
    if (resident > 0) resident--;
  endfunction

  function automatic void predict_pool(req_t r);
    int hit, victim, best, n;
    int order [NFR];
    hit = -1;
    if (r.op <= OP_FORCE_PAGE) begin
      for (int g = 0; g < NFR; g++)
        if (hit < 0 && fr_valid[g] && fr_file[g] == r.file && fr_page[g] == r.page) hit = g;
      if (r.op == OP_LOAD && hit < 0) begin
        victim = -1;
        if (resident >= NFR) begin
          best = NFR + 1;
          for (int g = 0; g < NFR; g++)
            if (fr_valid[g] && !fr_pinned[g] && fr_rank[g] < best) begin
              best = fr_rank[g]; victim = g;
            end
          if (victim < 0) begin
            push_beat(ST_NOFRAME, r.file, r.page, 1'b1);
            return;
          end
          if (fr_dirty[victim]) push_beat(ST_WRITEBACK, fr_file[victim], fr_page[victim], 1'b0);
          free_frame(victim);
        end else begin
          for (int g = NFR - 1; g >= 0; g--) if (!fr_valid[g]) victim = g;
        end
        fr_valid[victim] = 1; fr_pinned[victim] = 1; fr_dirty[victim] = 0;
        fr_file[victim] = r.file; fr_page[victim] = r.page;
        fr_rank[victim] = resident;
        resident++;
        push_beat(ST_MISS, r.file, r.page, 1'b1);
      end else if (hit < 0) begin
        push_beat(ST_NOTFOUND, r.file, r.page, 1'b1);
      end else begin
        case (r.op)
          OP_LOAD: begin
            make_mru(hit);
            push_beat(ST_HIT, r.file, r.page, 1'b1);
          end
          OP_PIN: begin
            fr_pinned[hit] = 1;
            push_beat(ST_DONE, r.file, r.page, 1'b1);
          end
          OP_UNPIN: begin
            fr_pinned[hit] = 0;
            push_beat(ST_DONE, r.file, r.page, 1'b1);
          end
          OP_DIRTY: begin
            fr_dirty[hit] = 1;
            push_beat(ST_DONE, r.file, r.page, 1'b1);
          end
          default: begin
            if (fr_dirty[hit]) push_beat(ST_WRITEBACK, r.file, r.page, 1'b0);
            fr_dirty[hit] = 0;
            make_mru(hit);
            push_beat(ST_DONE, r.file, r.page, 1'b1);
          end
        endcase
      end
      return;
    end
    n = 0;
    for (int k = 0; k < resident; k++)
      for (int g = 0; g < NFR; g++)
        if (fr_valid[g] && fr_rank[g] == k) begin
          order[n] = g;
          n++;
          break;
        end
    for (int j = 0; j < n; j++) begin
      int g;
      g = order[j];
      if (r.op != OP_REL_ALL && fr_file[g] != r.file) continue;
      if (fr_dirty[g]) push_beat(ST_WRITEBACK, fr_file[g], fr_page[g], 1'b0);
      if (r.op == OP_FORCE_FILE) begin
        fr_dirty[g] = 0;
        make_mru(g);
      end else free_frame(g);
    end
    push_beat(ST_DONE, r.op == OP_REL_ALL ? 4'd0 : r.file, 16'd0, 1'b1);
  endfunction

  function automatic req_t mk(op_t op, logic [3:0] f, logic [15:0] p);
    req_t r;
    r.op = op; r.file = f; r.page = p;
    return r;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_pool(req_t'({in_opcode, in_file_id, in_page_num}));
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      end
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_opcode <= r.op;
        in_file_id <= r.file;
        in_page_num <= r.page;
      end else in_valid <= 1'b0;
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        resp_t exp_b;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat status=%0d file=%0d page=%0d last=%0d",
                   $time, out_status, out_file, out_page, out_last);
          errors++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (exp_b.status != out_status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_b.status, out_status);
            errors++;
          end
          if (exp_b.file != out_file) begin
            $display("%0t: file expected %0d actual %0d", $time, exp_b.file, out_file);
            errors++;
          end
          if (exp_b.page != out_page) begin
            $display("%0t: page expected %0d actual %0d", $time, exp_b.page, out_page);
            errors++;
          end
          if (exp_b.last != out_last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_b.last, out_last);
            errors++;
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      end
      if (hold_off) out_ready <= 1'b0;
      else if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else out_ready <= 1'b1;
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("page_buffer_lru_pin_manager regression: fail");
      $finish;
    end
  end

  initial begin
    for (int g = 0; g < NFR; g++) begin
      fr_valid[g] = 0; fr_pinned[g] = 0; fr_dirty[g] = 0;
      fr_file[g] = 0; fr_page[g] = 0; fr_rank[g] = 0;
    end
    resident = 0;
    // directed
    queue_req(mk(OP_REL_ALL, 4'd0, 16'd0));
    queue_req(mk(OP_PIN, 4'd3, 16'd7));
    queue_req(mk(OP_FORCE_FILE, 4'd15, 16'hFFFF));
    for (int k = 0; k < 16; k++)
      queue_req(mk(OP_LOAD, k[3:0], k == 15 ? 16'hFFFF : 16'(k)));
    queue_req(mk(OP_LOAD, 4'd0, 16'd100));
    queue_req(mk(OP_LOAD, 4'd0, 16'd0));
    queue_req(mk(OP_UNPIN, 4'd0, 16'd0));
    queue_req(mk(OP_DIRTY, 4'd0, 16'd0));
    queue_req(mk(OP_LOAD, 4'd0, 16'd100));
    queue_req(mk(OP_FORCE_PAGE, 4'd15, 16'hFFFF));
    queue_req(mk(OP_REL_FILE, 4'd15, 16'd0));
    // random: small key space so hits, evictions and file walks are common
    for (int k = 0; k < 124; k++) begin
      req_t r;
      int sel;
      sel = $urandom_range(0, 99);
      r.op = sel < 35 ? OP_LOAD : sel < 45 ? OP_UNPIN : sel < 60 ? OP_DIRTY :
             sel < 67 ? OP_PIN : sel < 77 ? OP_FORCE_PAGE : sel < 87 ? OP_FORCE_FILE :
             sel < 95 ? OP_REL_FILE : OP_REL_ALL;
      r.file = $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3));
      r.page = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7));
      queue_req(r);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() < 120);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_beats.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0)
      $display("page_buffer_lru_pin_manager regression: pass");
    else
      $display("page_buffer_lru_pin_manager regression: fail");
    $finish;
  end
endmodule
